>>> sv/rtdpt_pkg.sv
// ----------------------------------------------------------------------------
// rtdpt_pkg
// Shared widths, constants, codes and item structs of the PT100 RTD
// temperature converter.
// ----------------------------------------------------------------------------
package rtdpt_pkg;

    localparam int RAW_W  = 16;
    localparam int REF_W  = 16;
    localparam int CODE_W = 15;
    localparam int PROD_W = 31;   // code * reference
    localparam int MULT_W = 59;   // product * discriminant slope
    localparam int DISC_W = 60;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int TEMP_W = 21;
    localparam int STAT_W = 2;
    localparam int SLOPE_W = 28;

    // discriminant scaled to integers: DISC_BASE - DISC_SLOPE * p
    localparam logic [SLOPE_W-1:0] DISC_SLOPE = 28'd231000000;
    localparam logic [DISC_W-1:0]  DISC_BASE  = DISC_W'(64'd1758480889 * 64'd3276800);
    localparam logic [ROOT_W-1:0]  A_SCALED   = 32'd1600839680;

    // temperature divisor 473088 = 231 << 11
    localparam int         T_DIV_SHIFT = 11;
    localparam logic [7:0] T_DIV_ODD   = 8'd231;
    localparam int         T_DIV_HALF  = 236544;

    localparam int SQ_STEPS    = 16;   // two root bits per step
    localparam int QUEUE_DEPTH = 4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAULT    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REF_ZERO = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

    localparam logic [TEMP_W-1:0] TEMP_MAX = 21'h0FFFFF;
    localparam logic [TEMP_W-1:0] TEMP_MIN = 21'h100000;

    typedef struct packed {
        logic ref_zero;
        logic fault;
        logic disc_neg;
    } rtdpt_flags_t;

    typedef struct packed {
        rtdpt_flags_t            flags;
        logic [RAD_W-1:0]        radicand;
    } rtdpt_job_t;

    typedef struct packed {
        rtdpt_flags_t            flags;
        logic [ROOT_W-1:0]       root;
    } rtdpt_root_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [TEMP_W-1:0]       temperature;
    } rtdpt_res_t;

endpackage

>>> sv/rtdpt_front.sv
// ----------------------------------------------------------------------------
// rtdpt_front
// Input side: holds the reference register, takes readings, classifies
// them and forms the square-root radicand in a three-stage pipeline.
// ----------------------------------------------------------------------------
module rtdpt_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rtdpt_pkg::REF_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rtdpt_pkg::RAW_W-1:0] s_raw,
    output logic                        push_valid,
    input  logic                        push_ready,
    output rtdpt_pkg::rtdpt_job_t       push_job
);
    import rtdpt_pkg::*;

    logic [REF_W-1:0]  ref_reg;
    logic              v1_reg, v2_reg, v3_reg;
    rtdpt_flags_t      f1_reg, f2_reg, f3_reg;
    logic [CODE_W-1:0] code_reg;
    logic [PROD_W-1:0] p_reg;
    logic [MULT_W-1:0] m_reg;
    logic              adv1, adv2, adv3, acc;
    logic [DISC_W-1:0] disc;

    assign adv3    = v3_reg && push_ready;
    assign adv2    = v2_reg && (!v3_reg || adv3);
    assign adv1    = v1_reg && (!v2_reg || adv2);
    assign s_ready = !v1_reg || adv1;
    assign acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                ref_reg <= cfg_data;
            end
            v1_reg <= acc  || (v1_reg && !adv1);
            v2_reg <= adv1 || (v2_reg && !adv2);
            v3_reg <= adv2 || (v3_reg && !adv3);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            // a set fault bit reads as a zero code
            code_reg        <= s_raw[0] ? '0 : s_raw[RAW_W-1:1];
            f1_reg.ref_zero <= (ref_reg == '0);
            f1_reg.fault    <= s_raw[0];
            f1_reg.disc_neg <= 1'b0;
        end
        if (adv1) begin
            p_reg  <= {16'b0, code_reg} * {15'b0, ref_reg};
            f2_reg <= f1_reg;
        end
        if (adv2) begin
            m_reg  <= {28'b0, p_reg} * {31'b0, DISC_SLOPE};
            f3_reg <= f2_reg;
        end
    end

    assign disc       = DISC_BASE - {1'b0, m_reg};
    assign push_valid = v3_reg;

    always_comb begin
        push_job.flags.ref_zero = f3_reg.ref_zero;
        push_job.flags.fault    = f3_reg.fault;
        push_job.flags.disc_neg = disc[DISC_W-1];
        // a non-negative discriminant stays below 2^53, times 512
        push_job.radicand       = {2'b00, disc[52:0], 9'b0};
    end

endmodule

>>> sv/rtdpt_queue.sv
// ----------------------------------------------------------------------------
// rtdpt_queue
// Short queue between the classifying front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module rtdpt_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rtdpt_pkg::rtdpt_job_t push_job,
    output logic                  pop_valid,
    input  logic                  pop_req,
    output rtdpt_pkg::rtdpt_job_t pop_job
);
    import rtdpt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rtdpt_job_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_req && pop_valid;
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_req |-> pop_valid)
        else $error("queue popped while empty");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

>>> sv/rtdpt_sqrt.sv
// ----------------------------------------------------------------------------
// rtdpt_sqrt
// Digit-recurrence integer square root of the 64-bit radicand, two root
// bits per cycle, with a hold register for the finished root.
// ----------------------------------------------------------------------------
module rtdpt_sqrt (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    output logic                   job_pop,
    input  rtdpt_pkg::rtdpt_job_t  job,
    output logic                   root_valid,
    input  logic                   root_ready,
    output rtdpt_pkg::rtdpt_root_t root_out
);
    import rtdpt_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(SQ_STEPS);

    typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_DONE} sq_state_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_acc_t;

    sq_state_t        state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0] rad_reg;
    sq_acc_t          acc_reg;
    rtdpt_flags_t     flags_reg;
    sq_acc_t          step1, acc_next;
    logic             load;

    function automatic sq_acc_t sq_step(sq_acc_t a, logic [1:0] pair);
        logic [REM_W+1:0] part;
        logic [REM_W+1:0] trial;
        sq_acc_t          r;
        part  = {a.rem, pair};
        trial = {2'b00, a.root, 2'b01};
        if (part >= trial) begin
            r.rem  = REM_W'(part - trial);
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = part[REM_W-1:0];
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    assign step1    = sq_step(acc_reg, rad_reg[RAD_W-1:RAD_W-2]);
    assign acc_next = sq_step(step1, rad_reg[RAD_W-3:RAD_W-4]);

    assign load       = job_valid &&
                        (state_reg == SQ_IDLE || (state_reg == SQ_DONE && root_ready));
    assign job_pop    = load;
    assign root_valid = (state_reg == SQ_DONE);

    always_comb begin
        root_out.flags = flags_reg;
        root_out.root  = acc_reg.root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                SQ_IDLE: begin
                    if (load) begin
                        state_reg <= SQ_RUN;
                    end
                end
                SQ_RUN: begin
                    acc_reg <= acc_next;
                    rad_reg <= rad_reg << 4;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQ_STEPS - 1)) begin
                        state_reg <= SQ_DONE;
                    end
                end
                SQ_DONE: begin
                    if (root_ready) begin
                        state_reg <= load ? SQ_RUN : SQ_IDLE;
                    end
                end
                default: begin
                    state_reg <= SQ_IDLE;
                end
            endcase
            if (load) begin
                rad_reg   <= job.radicand;
                acc_reg   <= '0;
                cnt_reg   <= '0;
                flags_reg <= job.flags;
            end
        end
    end

    // the radicand stays below 2^62, so the root fits in 31 bits
    a_root_width: assert property (@(posedge aclk) disable iff (!aresetn)
        root_valid |-> !acc_reg.root[ROOT_W-1])
        else $error("square root wider than expected");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_RUN) |-> !job_pop)
        else $error("item taken while root in progress");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_RUN && cnt_reg == CNT_W'(SQ_STEPS - 1)) |=> root_valid)
        else $error("root not finished after last step");

endmodule

>>> sv/rtdpt_div.sv
// ----------------------------------------------------------------------------
// rtdpt_div
// Forms the scaled temperature from the root: rounded division by the
// constant divisor through reciprocal multiplication in the states DV_QHI,
// DV_REM and DV_QLO, then saturation and status.
// ----------------------------------------------------------------------------
module rtdpt_div #(
    parameter int TEMP_FRAC_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   root_valid,
    output logic                   root_ready,
    input  rtdpt_pkg::rtdpt_root_t root_in,
    output logic                   res_valid,
    input  logic                   res_ready,
    output rtdpt_pkg::rtdpt_res_t  res
);
    import rtdpt_pkg::*;

    localparam int MAG_W = ROOT_W;
    // magnitude splits as qa * 473088 + ra, each part divided by 231 exactly
    localparam int HI_W  = MAG_W - T_DIV_SHIFT;
    localparam int K1    = HI_W + 8;
    localparam int M1_W  = HI_W + 1;
    localparam int QA_W  = HI_W + M1_W - K1;
    localparam int RA_W  = T_DIV_SHIFT + 8;
    localparam int SUM_W = RA_W + TEMP_FRAC_BITS;
    localparam int LO_W  = TEMP_FRAC_BITS + 8;
    localparam int K2    = LO_W + 8;
    localparam int M2_W  = LO_W + 1;
    localparam int QW    = 32;

    localparam longint ODD = longint'(T_DIV_ODD);
    localparam longint M1  = ((longint'(1) <<< K1) + ODD - 1) / ODD;
    localparam longint M2  = ((longint'(1) <<< K2) + ODD - 1) / ODD;

    localparam longint ZREF_MAG = ((longint'(27315) <<< TEMP_FRAC_BITS) + 50) / 100;
    localparam logic [TEMP_W-1:0] ZREF_TEMP =
        (ZREF_MAG > 1048576) ? TEMP_MIN : TEMP_W'(-ZREF_MAG);
    localparam logic [QW-1:0] Q_POS_MAX = QW'(1048575);
    localparam logic [QW-1:0] Q_NEG_MAX = QW'(1048576);

    typedef enum logic [2:0] {DV_IDLE, DV_QHI, DV_REM, DV_QLO, DV_DONE} dv_state_t;

    dv_state_t            state_reg;
    rtdpt_flags_t         flags_reg;
    logic                 neg_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [QA_W-1:0]      qa_reg;
    logic [LO_W-1:0]      lo_reg;
    logic [QW-1:0]        q_reg;
    logic                 take;
    logic [MAG_W:0]       num;
    logic [HI_W+M1_W-1:0] hi_prod;
    logic [7:0]           odd_low;
    logic [RA_W-1:0]      ra;
    logic [SUM_W-1:0]     lo_sum;
    logic [LO_W+M2_W-1:0] lo_prod;
    logic                 over;
    logic [TEMP_W-1:0]    t_plain;

    assign root_ready = (state_reg == DV_IDLE) || (state_reg == DV_DONE && res_ready);
    assign take       = root_valid && root_ready;
    assign res_valid  = (state_reg == DV_DONE);

    assign num     = {1'b0, A_SCALED} - {1'b0, root_in.root};
    assign hi_prod = {{M1_W{1'b0}}, mag_reg[MAG_W-1:T_DIV_SHIFT]}
                   * {{HI_W{1'b0}}, M1_W'(M1)};
    // ra stays below 2^19, so only the low byte of qa * 231 matters
    assign odd_low = qa_reg[7:0] * T_DIV_ODD;
    assign ra      = mag_reg[RA_W-1:0] - {odd_low, {T_DIV_SHIFT{1'b0}}};
    assign lo_sum  = (SUM_W'(ra) << TEMP_FRAC_BITS) + SUM_W'(T_DIV_HALF);
    assign lo_prod = {{M2_W{1'b0}}, lo_reg} * {{LO_W{1'b0}}, M2_W'(M2)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
        end else begin
            case (state_reg)
                DV_IDLE: begin
                    if (take) begin
                        state_reg <= DV_QHI;
                    end
                end
                DV_QHI: begin
                    qa_reg    <= hi_prod[HI_W+M1_W-1:K1];
                    state_reg <= DV_REM;
                end
                DV_REM: begin
                    lo_reg    <= lo_sum[SUM_W-1:T_DIV_SHIFT];
                    state_reg <= DV_QLO;
                end
                DV_QLO: begin
                    q_reg     <= QW'({qa_reg, {TEMP_FRAC_BITS{1'b0}}})
                               + QW'(lo_prod[LO_W+M2_W-1:K2]);
                    state_reg <= DV_DONE;
                end
                DV_DONE: begin
                    if (res_ready) begin
                        state_reg <= take ? DV_QHI : DV_IDLE;
                    end
                end
                default: begin
                    state_reg <= DV_IDLE;
                end
            endcase
            if (take) begin
                flags_reg <= root_in.flags;
                neg_reg   <= num[MAG_W];
                mag_reg   <= num[MAG_W] ? MAG_W'(-num) : num[MAG_W-1:0];
            end
        end
    end

    assign over    = neg_reg ? (q_reg > Q_NEG_MAX) : (q_reg > Q_POS_MAX);
    assign t_plain = neg_reg ? (~q_reg[TEMP_W-1:0] + 1'b1) : q_reg[TEMP_W-1:0];

    always_comb begin
        if (flags_reg.ref_zero) begin
            res.temperature = ZREF_TEMP;
            res.status      = STAT_REF_ZERO;
        end else if (flags_reg.disc_neg) begin
            res.temperature = TEMP_MAX;
            res.status      = flags_reg.fault ? STAT_FAULT : STAT_RANGE;
        end else begin
            res.temperature = over ? (neg_reg ? TEMP_MIN : TEMP_MAX) : t_plain;
            res.status      = flags_reg.fault ? STAT_FAULT : (over ? STAT_RANGE : STAT_OK);
        end
    end

endmodule

>>> sv/rtd_pt100_temperature.sv
// ----------------------------------------------------------------------------
// rtd_pt100_temperature
// PT100 temperature from an RTD converter reading, inverse Callendar-Van
// Dusen quadratic with an integer square root.
//
// s_tdata carries one 16-bit reading (bits 15..1 ratio code, bit 0 fault).
// m_tdata carries the signed temperature in 1/2^TEMP_FRAC_BITS degC and a
// two-bit status (ok, fault bit, reference zero, out of range).
// cfg_valid/cfg_data write the reference resistor in ohms; cfg_ready is
// always high. Write it only while no item is in flight.
// An accepted input passes the three front stages, the queue, the root unit,
// the divider and the output register before m_tvalid. The root unit sets the
// rate: it loads an item and runs sixteen two-bit steps before the next. The
// divider works on the previous item by reciprocal multiplication.
// Reset clears the reference to zero and empties the pipeline and queue.
// A stalled m_tready holds the result in the output register; the divider,
// root unit, four-item queue and three front stages fill, then s_tready drops.
// ----------------------------------------------------------------------------
module rtd_pt100_temperature #(
    parameter int TEMP_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,     // ref_resistance
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // raw_reading[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // temperature[20:0], status[22:21], zero pad
);
    import rtdpt_pkg::*;

    logic        push_valid, push_ready;
    rtdpt_job_t  push_job;
    logic        pop_valid, pop_req;
    rtdpt_job_t  pop_job;
    logic        root_valid, root_ready;
    rtdpt_root_t root;
    logic        res_valid, res_ready;
    rtdpt_res_t  res;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    assign cfg_ready = 1'b1;

    rtdpt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_raw      (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    rtdpt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_req    (pop_req),
        .pop_job    (pop_job)
    );

    rtdpt_sqrt u_sqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (pop_valid),
        .job_pop    (pop_req),
        .job        (pop_job),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root_out   (root)
    );

    rtdpt_div #(
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root_in    (root),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register parts the divider from the receiver
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= res_valid || (m_tvalid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {1'b0, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
